// ===== hdl/lpfp_pkg.sv =====
// lpfp_pkg: shared types and constants of the length-prefixed frame parser
// no dependencies; imported by every lpfp module and the top level
package lpfp_pkg;

  // parser phase, one-hot
  typedef enum logic [6:0] {
    PH_SYNC0 = 7'b0000001,
    PH_SYNC1 = 7'b0000010,
    PH_LEN0  = 7'b0000100,
    PH_LEN1  = 7'b0001000,
    PH_ID    = 7'b0010000,
    PH_CSUM  = 7'b0100000,
    PH_DATA  = 7'b1000000
  } lpfp_phase_t;

  // register select, taken from the word address bit of paddr
  localparam logic REG_HEADER_FIRST  = 1'b0;
  localparam logic REG_HEADER_SECOND = 1'b1;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [7:0] HEADER_FIRST_RST  = 8'd36;
  localparam logic [7:0] HEADER_SECOND_RST = 8'd75;

  // one result item
  typedef struct packed {
    logic        has_data;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic        last;
    logic [7:0]  msg_id;
    logic [7:0]  frame_checksum;
    logic [15:0] payload_length;
  } lpfp_result_t;

  // sync byte settings from the register block
  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
  } lpfp_cfg_t;

endpackage

// ===== hdl/lpfp_regs.sv =====
// lpfp_regs: APB-style configuration registers (sync byte values)
// depends on lpfp_pkg
module lpfp_regs
  import lpfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output lpfp_cfg_t          cfg
);

  logic write_en;
  logic reg_sel;

  assign pready   = 1'b1;
  assign write_en = psel & penable & pwrite;
  assign reg_sel  = paddr[2];

  // register writes on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first  <= HEADER_FIRST_RST;
      cfg.header_second <= HEADER_SECOND_RST;
    end else if (write_en) begin
      unique case (reg_sel)
        REG_HEADER_FIRST:  cfg.header_first  <= pwdata[7:0];
        REG_HEADER_SECOND: cfg.header_second <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_HEADER_FIRST:  prdata[7:0] = cfg.header_first;
      REG_HEADER_SECOND: prdata[7:0] = cfg.header_second;
      default: prdata = '0;
    endcase
  end

endmodule

// ===== hdl/lpfp_in_stage.sv =====
// lpfp_in_stage: input register holding one received byte
// depends on lpfp_pkg
module lpfp_in_stage
  import lpfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  // a new byte may enter when the slot is empty or is moving on
  assign in_ready = ~held_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // byte payload, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= rx_byte;
    end
  end

endmodule

// ===== hdl/lpfp_parser.sv =====
// lpfp_parser: frame phase machine, header capture and payload counter
// depends on lpfp_pkg
module lpfp_parser
  import lpfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  lpfp_cfg_t    cfg,
  input  logic         item_fire,
  input  logic [7:0]   item_byte,
  output logic         res_valid,
  output lpfp_result_t res
);

  lpfp_phase_t phase, phase_next;
  logic [15:0] declared_length, declared_length_next;
  logic [7:0]  captured_id, captured_id_next;
  logic [7:0]  captured_checksum, captured_checksum_next;
  logic [15:0] received_count, received_count_next;
  logic [15:0] count_inc;

  assign count_inc = received_count + 16'd1;

  // next state and result for the byte in the input register
  always_comb begin
    phase_next             = phase;
    declared_length_next   = declared_length;
    captured_id_next       = captured_id;
    captured_checksum_next = captured_checksum;
    received_count_next    = received_count;
    res_valid              = 1'b0;
    res.has_data           = 1'b0;
    res.data_byte          = 8'd0;
    res.byte_index         = 16'd0;
    res.last               = 1'b0;
    unique case (phase)
      PH_SYNC1: begin
        phase_next = (item_byte == cfg.header_second) ? PH_LEN0 : PH_SYNC0;
      end
      PH_LEN0: begin
        declared_length_next = {8'd0, item_byte};
        phase_next           = PH_LEN1;
      end
      PH_LEN1: begin
        declared_length_next = {item_byte, declared_length[7:0]};
        phase_next           = PH_ID;
      end
      PH_ID: begin
        captured_id_next = item_byte;
        phase_next       = PH_CSUM;
      end
      PH_CSUM: begin
        captured_checksum_next = item_byte;
        received_count_next    = 16'd0;
        // zero length: empty message ends here
        if (declared_length == 16'd0) begin
          phase_next = PH_SYNC0;
          res_valid  = 1'b1;
          res.last   = 1'b1;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        received_count_next = count_inc;
        res_valid           = 1'b1;
        res.has_data        = 1'b1;
        res.data_byte       = item_byte;
        res.byte_index      = received_count;
        res.last            = (count_inc == declared_length);
        if (count_inc == declared_length) begin
          phase_next = PH_SYNC0;
        end
      end
      default: begin
        // hunt for the first sync byte
        phase_next = PH_SYNC0;
        if (item_byte == cfg.header_first) begin
          declared_length_next = 16'd0;
          captured_id_next     = 8'd0;
          received_count_next  = 16'd0;
          phase_next           = PH_SYNC1;
        end
      end
    endcase
    res.msg_id         = captured_id_next;
    res.frame_checksum = captured_checksum_next;
    res.payload_length = declared_length_next;
  end

  // state update on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_SYNC0;
      declared_length   <= 16'd0;
      captured_id       <= 8'd0;
      captured_checksum <= 8'd0;
      received_count    <= 16'd0;
    end else if (item_fire) begin
      phase             <= phase_next;
      declared_length   <= declared_length_next;
      captured_id       <= captured_id_next;
      captured_checksum <= captured_checksum_next;
      received_count    <= received_count_next;
    end
  end

endmodule

// ===== hdl/lpfp_out_stage.sv =====
// lpfp_out_stage: result register toward the output channel
// depends on lpfp_pkg
module lpfp_out_stage
  import lpfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  logic         res_valid,
  input  lpfp_result_t res,
  output logic         advance,
  output logic         out_valid,
  input  logic         out_ready,
  output lpfp_result_t out_res
);

  // register is free when empty or its transfer completes now
  assign advance = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load & res_valid;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (advance && load && res_valid) begin
      out_res <= res;
    end
  end

endmodule

// ===== hdl/length_prefixed_frame_parser.sv =====
// length_prefixed_frame_parser: top level of the length-prefixed frame parser
// depends on lpfp_pkg, lpfp_regs, lpfp_in_stage, lpfp_parser, lpfp_out_stage
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   input    | in_valid/in_ready    | rx_byte
//   output   | out_valid/out_ready  | has_data, data_byte, byte_index, last,
//            |                      | msg_id, frame_checksum, payload_length
//   config   | psel/penable/pready  | paddr, pwrite, pwdata, prdata
//
// one byte per cycle sustained while out_ready stays high; a byte is first captured in
// the input register, then the parser result for it is loaded into the result register
// header bytes produce no result; payload bytes and an empty message do
// synchronous reset clears the phase machine, counters and both valid flags
// a stalled output holds the result register and backs up into the input
// register; in_ready follows out_ready combinationally
module length_prefixed_frame_parser
  import lpfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               has_data,
  output logic [7:0]         data_byte,
  output logic [15:0]        byte_index,
  output logic               last,
  output logic [7:0]         msg_id,
  output logic [7:0]         frame_checksum,
  output logic [15:0]        payload_length
);

  lpfp_cfg_t    cfg;
  logic         advance;
  logic         held_valid;
  logic [7:0]   held_byte;
  logic         item_fire;
  logic         res_valid;
  lpfp_result_t res;
  lpfp_result_t out_res;

  // configuration registers
  lpfp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  lpfp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  // held byte is processed when the result register can move
  assign item_fire = held_valid & advance;

  lpfp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item_fire (item_fire),
    .item_byte (held_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  lpfp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (held_valid),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign has_data       = out_res.has_data;
  assign data_byte      = out_res.data_byte;
  assign byte_index     = out_res.byte_index;
  assign last           = out_res.last;
  assign msg_id         = out_res.msg_id;
  assign frame_checksum = out_res.frame_checksum;
  assign payload_length = out_res.payload_length;

endmodule
